[rtl/core/vcsp_pkg.sv]
`default_nettype none
package vcsp_pkg;

  // Parameter buffer geometry
  localparam int MAX_PARAMS  = 8;
  localparam int PARAM_IDX_W = $clog2(MAX_PARAMS);
  localparam int COUNT_W     = 4;

  // Stream widths: command, char_code and eight parameter bytes, padded to bytes
  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 4;
  localparam int PAYLOAD_W   = CMD_W + BYTE_W + MAX_PARAMS * BYTE_W;
  localparam int OUT_DATA_W  = ((PAYLOAD_W + 7) / 8) * 8;

  // Command codes on the output
  localparam logic [CMD_W-1:0] CMD_PRINT     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_BACKSPACE = 4'd1;
  localparam logic [CMD_W-1:0] CMD_LINEFEED  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_CLS       = 4'd3;
  localparam logic [CMD_W-1:0] CMD_CR        = 4'd4;
  localparam logic [CMD_W-1:0] CMD_CLG       = 4'd5;
  localparam logic [CMD_W-1:0] CMD_COLOUR    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_GCOL      = 4'd7;
  localparam logic [CMD_W-1:0] CMD_DEFINE    = 4'd8;
  localparam logic [CMD_W-1:0] CMD_MODE      = 4'd9;
  localparam logic [CMD_W-1:0] CMD_GVIEWPORT = 4'd10;
  localparam logic [CMD_W-1:0] CMD_PLOT      = 4'd11;

  // Control bytes of the input stream
  localparam logic [BYTE_W-1:0] CTL_BS      = 8'd8;
  localparam logic [BYTE_W-1:0] CTL_LF      = 8'd10;
  localparam logic [BYTE_W-1:0] CTL_FF      = 8'd12;
  localparam logic [BYTE_W-1:0] CTL_CR      = 8'd13;
  localparam logic [BYTE_W-1:0] CTL_CLG     = 8'd16;
  localparam logic [BYTE_W-1:0] CTL_COLOUR  = 8'd17;
  localparam logic [BYTE_W-1:0] CTL_GCOL    = 8'd18;
  localparam logic [BYTE_W-1:0] CTL_DEFINE  = 8'd19;
  localparam logic [BYTE_W-1:0] CTL_MODE    = 8'd22;
  localparam logic [BYTE_W-1:0] CTL_GVIEW   = 8'd24;
  localparam logic [BYTE_W-1:0] CTL_PLOT    = 8'd25;
  localparam logic [BYTE_W-1:0] FIRST_PRINT = 8'd32;

  // Decoded meaning of a byte seen while nothing is pending
  typedef struct packed {
    logic               emit;
    logic               start;
    logic [CMD_W-1:0]   cmd;
    logic [COUNT_W-1:0] count;
  } code_info_t;

  // One result item
  typedef struct packed {
    logic [CMD_W-1:0]                  cmd;
    logic [BYTE_W-1:0]                 char_code;
    logic [MAX_PARAMS-1:0][BYTE_W-1:0] params;
  } result_t;

  function automatic code_info_t decode_code(input logic [BYTE_W-1:0] b);
    code_info_t info;
    info = '{emit: 1'b0, start: 1'b0, cmd: CMD_PRINT, count: '0};
    if (b >= FIRST_PRINT) begin
      info.emit = 1'b1;
    end else begin
      unique case (b)
        CTL_BS:     begin info.emit = 1'b1; info.cmd = CMD_BACKSPACE; end
        CTL_LF:     begin info.emit = 1'b1; info.cmd = CMD_LINEFEED; end
        CTL_FF:     begin info.emit = 1'b1; info.cmd = CMD_CLS; end
        CTL_CR:     begin info.emit = 1'b1; info.cmd = CMD_CR; end
        CTL_CLG:    begin info.emit = 1'b1; info.cmd = CMD_CLG; end
        CTL_COLOUR: begin info.start = 1'b1; info.cmd = CMD_COLOUR; info.count = 4'd1; end
        CTL_GCOL:   begin info.start = 1'b1; info.cmd = CMD_GCOL; info.count = 4'd2; end
        CTL_DEFINE: begin info.start = 1'b1; info.cmd = CMD_DEFINE; info.count = 4'd5; end
        CTL_MODE:   begin info.start = 1'b1; info.cmd = CMD_MODE; info.count = 4'd1; end
        CTL_GVIEW:  begin info.start = 1'b1; info.cmd = CMD_GVIEWPORT; info.count = 4'd8; end
        CTL_PLOT:   begin info.start = 1'b1; info.cmd = CMD_PLOT; info.count = 4'd5; end
        default:    info.emit = 1'b0;
      endcase
    end
    return info;
  endfunction

endpackage
`default_nettype wire

[rtl/core/vdu_control_stream_parser_unit.sv]
`default_nettype none
// A byte accepted into in_byte is parsed, and any result it forms is loaded into out_result on m_tdata.
// Throughput: one byte per cycle; the input register frees whenever the output
// register is empty or is taken in the same cycle.
// Reset (rst, synchronous): clears the valid flags of both registers and any pending command;
// the parameter buffer keeps its contents and is only read after being written.
module vdu_control_stream_parser_unit
  import vcsp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] byte_in
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata    // [3:0] command, [11:4] char_code,
                                                // [19:12] param_0 .. [75:68] param_7
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  logic              emit;
  result_t           result;
  result_t           out_result;

  // Process the held byte once the output register can take a result
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Hold the incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  vcsp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .byte_in (in_byte),
    .emit    (emit),
    .result  (result)
  );

  // Drop the output once taken, load a new result when one is formed
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_result <= result;
    end
  end

  // Pack the result, command in the lowest bits
  always_comb begin
    m_tdata = '0;
    m_tdata[CMD_W-1:0]              = out_result.cmd;
    m_tdata[CMD_W +: BYTE_W]        = out_result.char_code;
    for (int j = 0; j < MAX_PARAMS; j++) begin
      m_tdata[CMD_W + BYTE_W + j*BYTE_W +: BYTE_W] = out_result.params[j];
    end
  end

endmodule
`default_nettype wire

[rtl/core/vcsp_parser.sv]
`default_nettype none
module vcsp_parser
  import vcsp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic [BYTE_W-1:0] byte_in,
  output logic                   emit,
  output result_t                result
);

  logic [CMD_W-1:0]   pending_command, pending_command_next;
  logic [COUNT_W-1:0] needed_count, needed_count_next;
  logic [COUNT_W-1:0] fill_index, fill_index_next;
  logic [BYTE_W-1:0]  param_buffer [MAX_PARAMS];

  logic               pending;
  logic               finish;
  logic [COUNT_W-1:0] fill_inc;
  code_info_t         info;

  assign pending  = (needed_count != '0);
  assign fill_inc = fill_index + COUNT_W'(1);
  assign finish   = pending && (fill_inc == needed_count);
  assign info     = decode_code(byte_in);

  // Form the result and the next parse state
  always_comb begin
    pending_command_next = pending_command;
    needed_count_next    = needed_count;
    fill_index_next      = fill_index;
    emit                 = 1'b0;
    result.cmd           = CMD_PRINT;
    result.char_code     = '0;
    for (int j = 0; j < MAX_PARAMS; j++) begin
      result.params[j] = '0;
    end
    if (pending) begin
      fill_index_next = fill_inc;
      if (finish) begin
        emit                 = 1'b1;
        result.cmd           = pending_command;
        pending_command_next = CMD_PRINT;
        needed_count_next    = '0;
        fill_index_next      = '0;
        // Earlier parameters come from the buffer, the last one is this byte
        for (int j = 0; j < MAX_PARAMS; j++) begin
          if (COUNT_W'(j) == fill_index) begin
            result.params[j] = byte_in;
          end else if (COUNT_W'(j) < fill_index) begin
            result.params[j] = param_buffer[j];
          end
        end
      end
    end else begin
      emit       = info.emit;
      result.cmd = info.cmd;
      if (info.emit && info.cmd == CMD_PRINT) begin
        result.char_code = byte_in;
      end
      if (info.start) begin
        pending_command_next = info.cmd;
        needed_count_next    = info.count;
      end
    end
  end

  // Advance parse state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_command <= CMD_PRINT;
      needed_count    <= '0;
      fill_index      <= '0;
    end else if (advance) begin
      pending_command <= pending_command_next;
      needed_count    <= needed_count_next;
      fill_index      <= fill_index_next;
    end
  end

  // Store parameter bytes while a command is pending
  always_ff @(posedge clk) begin
    if (advance && pending && fill_index < COUNT_W'(MAX_PARAMS)) begin
      param_buffer[fill_index[PARAM_IDX_W-1:0]] <= byte_in;
    end
  end

endmodule
`default_nettype wire

[tb/tb_vdu_control_stream_parser_unit.sv]
module tb_vdu_control_stream_parser_unit;
  import vcsp_pkg::*;

  // How a byte is treated when nothing is pending
  typedef enum logic [1:0] {
    BC_IGNORED,
    BC_PRINTABLE,
    BC_IMMEDIATE,
    BC_PREFIX
  } byte_class_t;

  // One parsed command as it should leave the block
  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [BYTE_W-1:0]    chr;
    logic [7:0][BYTE_W-1:0] prm;
  } vdu_cmd_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  vdu_control_stream_parser_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] byte_in
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [3:0] command, [11:4] char_code, [19:12] param_0 .. [75:68] param_7
  );

  // Parser state mirrored by the predictor
  logic [CMD_W-1:0]  pend_cmd = CMD_PRINT;
  logic [3:0]        need_cnt = '0;
  logic [3:0]        fill_cnt = '0;
  logic [BYTE_W-1:0] param_store [8];

  logic [BYTE_W-1:0] stream_bytes [$];
  vdu_cmd_t          expected_cmds [$];

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  int   send_gap  = 0;
  int   recv_wait = 0;
  bit   send_calm = 1'b0;
  bit   recv_calm = 1'b0;
  int   mismatch_cnt = 0;
  int   bytes_sent   = 0;
  int   cmds_checked = 0;
  int   cmd_hits [12];

  logic [BYTE_W-1:0] immediates [5] = '{CTL_BS, CTL_LF, CTL_FF, CTL_CR, CTL_CLG};
  logic [BYTE_W-1:0] prefixes [6] =
    '{CTL_COLOUR, CTL_GCOL, CTL_DEFINE, CTL_MODE, CTL_GVIEW, CTL_PLOT};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Classify an idle-state byte; give the command and its parameter count
  function automatic byte_class_t classify(input logic [BYTE_W-1:0] b,
                                           output logic [CMD_W-1:0] cmd,
                                           output logic [3:0] cnt);
    cmd = CMD_PRINT;
    cnt = 4'd0;
    if (b >= FIRST_PRINT) return BC_PRINTABLE;
    case (b)
      CTL_BS:     begin cmd = CMD_BACKSPACE; return BC_IMMEDIATE; end
      CTL_LF:     begin cmd = CMD_LINEFEED;  return BC_IMMEDIATE; end
      CTL_FF:     begin cmd = CMD_CLS;       return BC_IMMEDIATE; end
      CTL_CR:     begin cmd = CMD_CR;        return BC_IMMEDIATE; end
      CTL_CLG:    begin cmd = CMD_CLG;       return BC_IMMEDIATE; end
      CTL_COLOUR: begin cmd = CMD_COLOUR;    cnt = 4'd1; return BC_PREFIX; end
      CTL_GCOL:   begin cmd = CMD_GCOL;      cnt = 4'd2; return BC_PREFIX; end
      CTL_DEFINE: begin cmd = CMD_DEFINE;    cnt = 4'd5; return BC_PREFIX; end
      CTL_MODE:   begin cmd = CMD_MODE;      cnt = 4'd1; return BC_PREFIX; end
      CTL_GVIEW:  begin cmd = CMD_GVIEWPORT; cnt = 4'd8; return BC_PREFIX; end
      CTL_PLOT:   begin cmd = CMD_PLOT;      cnt = 4'd5; return BC_PREFIX; end
      default:    return BC_IGNORED;
    endcase
  endfunction

  // Advance the parser by one byte; return 1 when a command completes
  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output vdu_cmd_t res);
    logic [CMD_W-1:0] cmd;
    logic [3:0]       cnt;
    byte_class_t      cls;
    res = '0;
    if (need_cnt != 4'd0) begin
      if (fill_cnt < 4'd8) param_store[fill_cnt[2:0]] = b;
      fill_cnt = fill_cnt + 4'd1;
      if (fill_cnt != need_cnt) return 1'b0;
      res.cmd = pend_cmd;
      for (int j = 0; j < 8; j++)
        if (j < need_cnt) res.prm[j] = param_store[j];
      pend_cmd = CMD_PRINT;
      need_cnt = 4'd0;
      fill_cnt = 4'd0;
      return 1'b1;
    end
    cls = classify(b, cmd, cnt);
    case (cls)
      BC_PRINTABLE: begin res.cmd = CMD_PRINT; res.chr = b; return 1'b1; end
      BC_IMMEDIATE: begin res.cmd = cmd; return 1'b1; end
      BC_PREFIX:    begin pend_cmd = cmd; need_cnt = cnt; fill_cnt = 4'd0; end
      default:      ;
    endcase
    return 1'b0;
  endfunction

  // Compare one field, report on mismatch
  task automatic check_field(input string fld, input logic [BYTE_W-1:0] e,
                             input logic [BYTE_W-1:0] a);
    if (a !== e) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, e, a);
    end
  endtask

  // Draw a wait from 0 to 4, with occasional calm stretches of no waiting
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = ~calm;
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // Request driver: present the next byte once the previous one is taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap--;
      end else if (stream_bytes.size() != 0) begin
        s_tdata  <= stream_bytes.pop_front();
        s_tvalid <= 1'b1;
        send_gap = draw_wait(send_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: stall a drawn number of valid cycles per result
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_taken) recv_wait = draw_wait(recv_calm);
      if (recv_wait > 0) begin
        m_tready <= 1'b0;
        if (m_tvalid) recv_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: check taken results first, then predict from taken bytes
  always @(posedge clk) begin
    vdu_cmd_t exp_cmd;
    vdu_cmd_t got;
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= s_tvalid && s_tready;
      out_taken <= m_tvalid && m_tready;
      if (m_tvalid && m_tready) begin
        got.cmd = m_tdata[3:0];
        got.chr = m_tdata[11:4];
        for (int j = 0; j < 8; j++) got.prm[j] = m_tdata[12 + 8*j +: 8];
        if (expected_cmds.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result, expected none, got %0h", $time, m_tdata);
        end else begin
          exp_cmd = expected_cmds.pop_front();
          cmds_checked++;
          if (exp_cmd.cmd < 12) cmd_hits[exp_cmd.cmd]++;
          check_field("command", BYTE_W'(exp_cmd.cmd), BYTE_W'(got.cmd));
          check_field("char_code", exp_cmd.chr, got.chr);
          for (int j = 0; j < 8; j++)
            check_field($sformatf("param_%0d", j), exp_cmd.prm[j], got.prm[j]);
          check_field("padding", '0, BYTE_W'(m_tdata[OUT_DATA_W-1:PAYLOAD_W]));
        end
      end
      if (s_tvalid && s_tready) begin
        bytes_sent++;
        if (parse_byte(s_tdata, exp_cmd)) expected_cmds.push_back(exp_cmd);
      end
    end
  end

  // Stimulus, then drain and verdict
  initial begin
    logic [BYTE_W-1:0] directed [$];
    logic [BYTE_W-1:0] b;
    logic [CMD_W-1:0]  k;
    logic [3:0]        n;
    int                pick;
    int                rand_items;
    int                kinds;

    // Extremes, every command, an ignored code, control codes as parameters
    directed = {FIRST_PRINT, 8'hFF, 8'h01,
                CTL_BS, CTL_LF, CTL_FF, CTL_CR, CTL_CLG,
                CTL_COLOUR, 8'hFF,
                CTL_MODE, 8'h00,
                CTL_GCOL, CTL_COLOUR, CTL_GVIEW,
                CTL_DEFINE, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                CTL_PLOT, 8'h20, 8'h40, 8'h80, 8'h7F, 8'hFE,
                CTL_GVIEW, 8'h00, CTL_BS, CTL_LF, 8'h1F, 8'h80, 8'hFF, 8'h55, 8'hAA};
    foreach (directed[i]) stream_bytes.push_back(directed[i]);

    // Mostly well-formed traffic with random content, some noise
    rand_items = 0;
    while (rand_items < 600) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        stream_bytes.push_back(8'($urandom_range(32, 255)));
        rand_items++;
      end else if (pick < 50) begin
        stream_bytes.push_back(immediates[$urandom_range(0, 4)]);
        rand_items++;
      end else if (pick < 85) begin
        b = prefixes[$urandom_range(0, 5)];
        void'(classify(b, k, n));
        stream_bytes.push_back(b);
        repeat (n) stream_bytes.push_back(8'($urandom_range(0, 255)));
        rand_items += 1 + n;
      end else if (pick < 92) begin
        do b = 8'($urandom_range(0, 31)); while (classify(b, k, n) != BC_IGNORED);
        stream_bytes.push_back(b);
      end else begin
        b = 8'($urandom_range(0, 255));
        stream_bytes.push_back(b);
        if (classify(b, k, n) != BC_IGNORED) rand_items++;
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stream_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    kinds = 0;
    foreach (cmd_hits[i]) if (cmd_hits[i] != 0) kinds++;
    $display("bytes sent: %0d, commands checked: %0d", bytes_sent, cmds_checked);
    $display("command kinds seen: %0d of 12", kinds);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("timeout with %0d commands outstanding", expected_cmds.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
